[design/assert_macros.svh]
// Assertion macros used by radial_profile_binning.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication whose consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/rpb_pkg.sv]
// ----------------------------------------------------------------------------
// Radial profile binning package
// Shared widths, command codes, register map and default parameter values.
// ----------------------------------------------------------------------------
package rpb_pkg;

    localparam int DEF_NUM_BINS         = 2048;
    localparam int DEF_MAX_DIM          = 2048;
    localparam int DEF_PIXEL_BITS       = 20;
    localparam int DEF_CENTER_FRAC_BITS = 8;

    localparam int CMD_W   = 2;
    localparam int PIX_W   = 20;
    localparam int SEL_W   = 11;
    localparam int AVG_W   = 28;
    localparam int CNT_W   = 23;
    localparam int SUM_W   = 48;
    localparam int RPC_W   = 12;
    localparam int CTR_W   = 20;
    localparam int ROW_W   = 11;
    localparam int COL_W   = 12;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_RPC     = 2'd0;
    localparam logic [1:0] REG_CTR_COL = 2'd1;
    localparam logic [1:0] REG_CTR_ROW = 2'd2;

    localparam logic [RPC_W-1:0] RPC_RESET = 12'd1024;
    localparam logic [CTR_W-1:0] CTR_RESET = 20'd262144;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [AVG_W-1:0] AVG_MAX = '1;
    localparam logic [SEL_W-1:0] BIN_SAT = '1;

endpackage

[design/rpb_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

[design/radial_profile_binning.sv]
// ----------------------------------------------------------------------------
// Radial profile binning
// Accumulates pixel intensities into radius bins and reports bin averages.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; busy is high while it runs. A pixel
// takes a multiply, an add and an iterative square root that gives one root
// bit per cycle (23 root bits at the default centre precision), then, when
// the bin is in range, a read and a write of the bin memory. A bin read takes
// a memory read and, when the bin holds data and is not bin 0 and its average
// does not saturate, a bit-serial division of 28 quotient bits, then shows the
// result for one cycle on result_valid; the receiver cannot stall it. After
// reset and after a clear command the bin memory is swept to zero, one entry
// a cycle over all NUM_BINS entries, with busy high.
`include "assert_macros.svh"

module radial_profile_binning #(
    parameter int NUM_BINS         = rpb_pkg::DEF_NUM_BINS,
    parameter int MAX_DIM          = rpb_pkg::DEF_MAX_DIM,
    parameter int PIXEL_BITS       = rpb_pkg::DEF_PIXEL_BITS,
    parameter int CENTER_FRAC_BITS = rpb_pkg::DEF_CENTER_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpb_pkg::PADDR_W-1:0] paddr,
    input  logic [rpb_pkg::PDATA_W-1:0] pwdata,
    output logic [rpb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [rpb_pkg::CMD_W-1:0]   cmd,
    input  logic [rpb_pkg::PIX_W-1:0]   pixel_value,
    input  logic [rpb_pkg::SEL_W-1:0]   bin_select,
    output logic                        result_valid,
    output logic [rpb_pkg::SEL_W-1:0]   bin_number,
    output logic [rpb_pkg::AVG_W-1:0]   average_q8,
    output logic [rpb_pkg::CNT_W-1:0]   bin_pixel_count,
    output logic [rpb_pkg::SEL_W-1:0]   largest_bin_seen,
    output logic                        range_overflow
);
    import rpb_pkg::*;

    localparam int F       = CENTER_FRAC_BITS;
    localparam int AW      = $clog2(NUM_BINS);
    localparam int DW      = (COL_W + 1 + F > CTR_W) ? COL_W + 1 + F : CTR_W;
    localparam int SQ_W    = 2 * DW;
    localparam int RAD_RAW = SQ_W + 3;
    localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int BINV_W  = ROOT_W + 1;
    localparam int SIT_W   = $clog2(ROOT_W + 1);
    localparam int MEM_W   = SUM_W + CNT_W;
    localparam int DIT_W   = $clog2(AVG_W + 1);
    localparam logic [PIX_W-1:0] PIX_MASK =
        (PIXEL_BITS >= PIX_W) ? '1 : PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);
    localparam logic [BINV_W-1:0] HALF_BIN = BINV_W'(64'd1 << F);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_BIN   = 4'd5;
    localparam logic [3:0] S_RMW   = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [RPC_W-1:0]  rpc_reg;
    logic [CTR_W-1:0]  ctr_col_reg, ctr_row_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SEL_W-1:0]  max_bin_reg, max_bin_next;
    logic              ovf_reg, ovf_next;
    logic [AW:0]       clr_cnt_reg, clr_cnt_next;

    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [DW-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  srem_reg, srem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIT_W-1:0]  sit_reg, sit_next;
    logic [AW-1:0]     bin_reg, bin_next;

    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic              sel_ok_reg, sel_ok_next;
    logic [CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]  drem_reg, drem_next;
    logic [AVG_W-1:0]  num_reg, num_next;
    logic [AVG_W-1:0]  quot_reg, quot_next;
    logic [DIT_W-1:0]  dit_reg, dit_next;

    logic              valid_reg, valid_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [MEM_W-1:0]  mem_wdata, mem_rdata;
    logic [SUM_W-1:0]  rd_sum;
    logic [CNT_W-1:0]  rd_cnt;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_new;
    logic [CNT_W-1:0]  cnt_new;

    logic              accept, cfg_wr;
    logic [13:0]       rpc_eff;
    logic [DW-1:0]     col_fp, row_fp, cc_ext, cr_ext;
    logic [REM_W-1:0]  srem_sh, strial;
    logic [BINV_W-1:0] binv;
    logic [CNT_W:0]    drem_sh;

    rpb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RPC:     prdata = PDATA_W'(rpc_reg);
            REG_CTR_COL: prdata = PDATA_W'(ctr_col_reg);
            REG_CTR_ROW: prdata = PDATA_W'(ctr_row_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpc_reg     <= RPC_RESET;
            ctr_col_reg <= CTR_RESET;
            ctr_row_reg <= CTR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RPC:     rpc_reg     <= pwdata[RPC_W-1:0];
                REG_CTR_COL: ctr_col_reg <= pwdata[CTR_W-1:0];
                REG_CTR_ROW: ctr_row_reg <= pwdata[CTR_W-1:0];
                default:     ;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign rd_sum  = mem_rdata[MEM_W-1:CNT_W];
    assign rd_cnt  = mem_rdata[CNT_W-1:0];
    assign sum_add = {1'b0, rd_sum} + (SUM_W + 1)'(pix_reg);
    assign sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign cnt_new = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_W'(1);

    assign rpc_eff = (rpc_reg == '0) ? 14'd1 :
                     (32'(rpc_reg) > MAX_DIM) ? 14'(MAX_DIM) : 14'(rpc_reg);
    assign col_fp  = DW'({1'b0, col_reg} + 13'd1) << F;
    assign row_fp  = DW'({1'b0, row_reg} + 12'd1) << F;
    assign cc_ext  = DW'(ctr_col_reg);
    assign cr_ext  = DW'(ctr_row_reg);

    assign srem_sh = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign strial  = REM_W'({root_reg, 2'b01});
    assign binv    = {1'b0, root_reg} + HALF_BIN;
    assign drem_sh = {drem_reg, num_reg[AVG_W-1]};

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        max_bin_next = max_bin_reg;
        ovf_next     = ovf_reg;
        clr_cnt_next = clr_cnt_reg;
        pix_next     = pix_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        rad_next     = rad_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        sit_next     = sit_reg;
        bin_next     = bin_reg;
        sel_next     = sel_reg;
        sel_ok_next  = sel_ok_reg;
        div_cnt_next = div_cnt_reg;
        drem_next    = drem_reg;
        num_next     = num_reg;
        quot_next    = quot_reg;
        dit_next     = dit_reg;
        valid_next   = 1'b0;
        avg_next     = avg_reg;
        cnt_out_next = cnt_out_reg;
        mem_we       = 1'b0;
        mem_waddr    = bin_reg;
        mem_wdata    = {sum_new, cnt_new};
        mem_re       = 1'b0;
        mem_raddr    = bin_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg[AW-1:0];
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + (AW + 1)'(1);
                if (clr_cnt_reg == (AW + 1)'(NUM_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_ACCUM:
                        begin
                            pix_next = pixel_value & PIX_MASK;
                            dx_next  = (col_fp >= cc_ext) ? col_fp - cc_ext : cc_ext - col_fp;
                            dy_next  = (row_fp >= cr_ext) ? row_fp - cr_ext : cr_ext - row_fp;
                            if (14'({1'b0, row_reg}) + 14'd1 >= rpc_eff)
                            begin
                                row_next = '0;
                                col_next = col_reg + COL_W'(1);
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                            state_next = S_MUL;
                        end
                        CMD_READ:
                        begin
                            sel_next    = bin_select;
                            sel_ok_next = (32'(bin_select) < NUM_BINS);
                            mem_re      = 1'b1;
                            mem_raddr   = AW'(bin_select);
                            state_next  = S_RD;
                        end
                        CMD_CLEAR:
                        begin
                            row_next     = '0;
                            col_next     = '0;
                            max_bin_next = '0;
                            ovf_next     = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                sqx_next   = dx_reg * dx_reg;
                sqy_next   = dy_reg * dy_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                rad_next   = RAD_W'({1'b0, sqx_reg} + {1'b0, sqy_reg}) << 2;
                srem_next  = '0;
                root_next  = '0;
                sit_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                rad_next = rad_reg << 2;
                if (srem_sh >= strial)
                begin
                    srem_next = srem_sh - strial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                sit_next = sit_reg + SIT_W'(1);
                if (sit_reg == SIT_W'(ROOT_W - 1))
                begin
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                if ((binv >> (F + 1)) >= BINV_W'(NUM_BINS))
                begin
                    ovf_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    bin_next  = AW'(binv >> (F + 1));
                    mem_re    = 1'b1;
                    mem_raddr = AW'(binv >> (F + 1));
                    if ((binv >> (F + 1)) > BINV_W'(max_bin_reg))
                    begin
                        max_bin_next = ((binv >> (F + 1)) > BINV_W'(BIN_SAT)) ?
                                       BIN_SAT : SEL_W'(binv >> (F + 1));
                    end
                    state_next = S_RMW;
                end
            end
            S_RMW:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                cnt_out_next = sel_ok_reg ? rd_cnt : '0;
                div_cnt_next = rd_cnt;
                if (!sel_ok_reg || sel_reg == '0 || rd_cnt == '0)
                begin
                    avg_next   = '0;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (rd_sum >= (SUM_W'(rd_cnt) << (AVG_W - 8)))
                begin
                    avg_next   = AVG_MAX;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    drem_next  = CNT_W'(rd_sum[SUM_W-1:AVG_W-8]);
                    num_next   = {rd_sum[AVG_W-9:0], 8'd0};
                    quot_next  = '0;
                    dit_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                num_next = num_reg << 1;
                if (drem_sh >= {1'b0, div_cnt_reg})
                begin
                    drem_next = CNT_W'(drem_sh - {1'b0, div_cnt_reg});
                    quot_next = {quot_reg[AVG_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = CNT_W'(drem_sh);
                    quot_next = {quot_reg[AVG_W-2:0], 1'b0};
                end
                dit_next = dit_reg + DIT_W'(1);
                if (dit_reg == DIT_W'(AVG_W - 1))
                begin
                    avg_next   = {quot_reg[AVG_W-2:0], (drem_sh >= {1'b0, div_cnt_reg})};
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            row_reg     <= '0;
            col_reg     <= '0;
            max_bin_reg <= '0;
            ovf_reg     <= 1'b0;
            clr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            max_bin_reg <= max_bin_next;
            ovf_reg     <= ovf_next;
            clr_cnt_reg <= clr_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        sit_reg     <= sit_next;
        bin_reg     <= bin_next;
        sel_reg     <= sel_next;
        sel_ok_reg  <= sel_ok_next;
        div_cnt_reg <= div_cnt_next;
        drem_reg    <= drem_next;
        num_reg     <= num_next;
        quot_reg    <= quot_next;
        dit_reg     <= dit_next;
        avg_reg     <= avg_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign result_valid     = valid_reg;
    assign bin_number       = sel_reg;
    assign average_q8       = avg_reg;
    assign bin_pixel_count  = cnt_out_reg;
    assign largest_bin_seen = max_bin_reg;
    assign range_overflow   = ovf_reg;

    `ASSERT_IMPLIES(a_result_while_busy, clk, rst_n, result_valid, state_reg == S_OUT)
    `ASSERT_NEXT(a_single_strobe, clk, rst_n, result_valid, !result_valid)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept && cmd != CMD_NOP, busy)
    `ASSERT_IMPLIES(a_no_write_on_read, clk, rst_n, state_reg == S_RD || state_reg == S_DIV, !mem_we)

endmodule

[test/radial_profile_binning_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radial profile binning testbench
// Drives pixels, bin reads, clears, no-ops and register writes into the block and
// checks every bin report against a cycle-free prediction of the binning or a fixed expected report.
// ----------------------------------------------------------------------------
module radial_profile_binning_test;
    import rpb_pkg::*;

    localparam int NBINS = DEF_NUM_BINS;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [SEL_W-1:0] bin;
        logic [AVG_W-1:0] avg;
        logic [CNT_W-1:0] cnt;
        logic [SEL_W-1:0] top;
        logic             ovf;
    } bin_report_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [PIX_W-1:0] pix;
        logic [SEL_W-1:0] sel;
        logic             typed;
        bin_report_t      want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [CMD_W-1:0] cmd = CMD_NOP;
    logic [PIX_W-1:0] pixel_value = '0;
    logic [SEL_W-1:0] bin_select = '0;
    logic result_valid;
    logic [SEL_W-1:0] bin_number;
    logic [AVG_W-1:0] average_q8;
    logic [CNT_W-1:0] bin_pixel_count;
    logic [SEL_W-1:0] largest_bin_seen;
    logic range_overflow;

    radial_profile_binning dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .cmd(cmd), .pixel_value(pixel_value),
        .bin_select(bin_select), .result_valid(result_valid), .bin_number(bin_number),
        .average_q8(average_q8), .bin_pixel_count(bin_pixel_count),
        .largest_bin_seen(largest_bin_seen), .range_overflow(range_overflow)
    );

    logic [SUM_W-1:0] sum_tab [NBINS];
    logic [CNT_W-1:0] cnt_tab [NBINS];
    logic [ROW_W-1:0] row_pos;
    logic [COL_W-1:0] col_pos;
    logic [SEL_W-1:0] top_bin;
    logic             ovf_flag;
    logic [RPC_W-1:0] rpc_reg;
    logic [CTR_W-1:0] ctr_col_reg;
    logic [CTR_W-1:0] ctr_row_reg;

    bin_report_t pending_reports[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        bin_report_t w;
        if (rst_n && result_valid) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report, bin", bin_number, 0);
            end
            else begin
                w = pending_reports.pop_front();
                if (bin_number !== w.bin) report_mismatch("bin_number", bin_number, w.bin);
                if (average_q8 !== w.avg) report_mismatch("average_q8", average_q8, w.avg);
                if (bin_pixel_count !== w.cnt)
                    report_mismatch("bin_pixel_count", bin_pixel_count, w.cnt);
                if (largest_bin_seen !== w.top)
                    report_mismatch("largest_bin_seen", largest_bin_seen, w.top);
                if (range_overflow !== w.ovf)
                    report_mismatch("range_overflow", range_overflow, w.ovf);
            end
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void clear_bins();
        for (int i = 0; i < NBINS; i++) begin
            sum_tab[i] = '0;
            cnt_tab[i] = '0;
        end
        row_pos = '0;
        col_pos = '0;
        top_bin = '0;
        ovf_flag = 1'b0;
    endfunction

    function automatic void bin_pixel(logic [PIX_W-1:0] pix);
        longint unsigned cx, cy, dx, dy, bin, s;
        longint unsigned rpc;
        logic [SUM_W:0] acc;
        cx = (longint'(col_pos) + 1) << DEF_CENTER_FRAC_BITS;
        cy = (longint'(row_pos) + 1) << DEF_CENTER_FRAC_BITS;
        dx = cx >= ctr_col_reg ? cx - ctr_col_reg : ctr_col_reg - cx;
        dy = cy >= ctr_row_reg ? cy - ctr_row_reg : ctr_row_reg - cy;
        s = int_sqrt((dx * dx + dy * dy) * 4);
        bin = (s + 256) / 512;
        if (bin >= NBINS) begin
            ovf_flag = 1'b1;
        end
        else begin
            acc = {1'b0, sum_tab[bin]} + pix;
            sum_tab[bin] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
            if (cnt_tab[bin] != CNT_MAX) cnt_tab[bin] = cnt_tab[bin] + 1'b1;
            if (bin > top_bin) top_bin = bin[SEL_W-1:0];
        end
        rpc = rpc_reg == 0 ? 1 : (rpc_reg > DEF_MAX_DIM ? DEF_MAX_DIM : rpc_reg);
        if (longint'(row_pos) + 1 >= rpc) begin
            row_pos = '0;
            col_pos = col_pos + 1'b1;
        end
        else begin
            row_pos = row_pos + 1'b1;
        end
    endfunction

    function automatic bin_report_t bin_lookup(logic [SEL_W-1:0] sel);
        bin_report_t r;
        longint unsigned a;
        r.bin = sel;
        r.cnt = cnt_tab[sel];
        r.avg = '0;
        if (sel != 0 && cnt_tab[sel] != 0) begin
            a = (longint'(sum_tab[sel]) << 8) / cnt_tab[sel];
            r.avg = a > AVG_MAX ? AVG_MAX : a[AVG_W-1:0];
        end
        r.top = top_bin;
        r.ovf = ovf_flag;
        return r;
    endfunction

    // Issues one transaction; returns at the falling edge after it was taken.
    task automatic issue(logic [CMD_W-1:0] op, logic [PIX_W-1:0] pix,
                         logic [SEL_W-1:0] sel, bit typed, bin_report_t want);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        while (busy) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        cmd = op;
        pixel_value = pix;
        bin_select = sel;
        case (op)
            CMD_ACCUM: bin_pixel(pix);
            CMD_CLEAR: clear_bins();
            CMD_READ: pending_reports.push_back(typed ? want : bin_lookup(sel));
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic settle();
        start = 1'b0;
        @(negedge clk);
        while (busy || pending_reports.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
        settle();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = PADDR_W'(idx) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_RPC: rpc_reg = value[RPC_W-1:0];
            REG_CTR_COL: ctr_col_reg = value[CTR_W-1:0];
            default: ctr_row_reg = value[CTR_W-1:0];
        endcase
    endtask

    task automatic random_phase(int n, int max_sel);
        int k;
        logic [SEL_W-1:0] sel;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            sel = ($urandom_range(9) == 0) ? SEL_W'($urandom) : SEL_W'($urandom_range(max_sel));
            if (k < 62) issue(CMD_ACCUM, PIX_W'($urandom), sel, 0, '0);
            else if (k < 94) issue(CMD_READ, PIX_W'($urandom), sel, 0, '0);
            else if (k < 97) issue(CMD_NOP, PIX_W'($urandom), sel, 0, '0);
            else issue(CMD_CLEAR, PIX_W'($urandom), sel, 0, '0);
        end
    endtask

    stim_row_t directed [] = '{
        '{CMD_READ,  20'd0,       11'd0,    1'b1, '{11'd0, 28'd0, 23'd0, 11'd0, 1'b0}},
        '{CMD_READ,  20'hFFFFF,   11'd2047, 1'b1, '{11'd2047, 28'd0, 23'd0, 11'd0, 1'b0}},
        '{CMD_NOP,   20'hFFFFF,   11'd5,    1'b0, '0},
        '{CMD_ACCUM, 20'hFFFFF,   11'd0,    1'b0, '0},
        '{CMD_ACCUM, 20'd0,       11'd0,    1'b0, '0},
        '{CMD_ACCUM, 20'd1,       11'h7FF,  1'b0, '0},
        '{CMD_ACCUM, 20'h55555,   11'd0,    1'b0, '0},
        '{CMD_ACCUM, 20'hAAAAA,   11'd0,    1'b0, '0},
        '{CMD_READ,  20'd0,       11'd0,    1'b0, '0},
        '{CMD_READ,  20'd0,       11'd1,    1'b0, '0},
        '{CMD_READ,  20'd0,       11'd2,    1'b0, '0},
        '{CMD_READ,  20'd0,       11'd3,    1'b0, '0},
        '{CMD_CLEAR, 20'hFFFFF,   11'h7FF,  1'b0, '0},
        '{CMD_READ,  20'd0,       11'd1,    1'b1, '{11'd1, 28'd0, 23'd0, 11'd0, 1'b0}}
    };

    initial begin
        clear_bins();
        rpc_reg = RPC_RESET;
        ctr_col_reg = CTR_RESET;
        ctr_row_reg = CTR_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Centre on pixel (1,1) with three rows a column so bins stay small.
        write_reg(REG_RPC, 32'd3);
        write_reg(REG_CTR_COL, 32'd256);
        write_reg(REG_CTR_ROW, 32'd256);
        foreach (directed[i])
            issue(directed[i].op, directed[i].pix, directed[i].sel,
                  directed[i].typed, directed[i].want);

        idle_pct = 18;
        write_reg(REG_RPC, 32'd16);
        write_reg(REG_CTR_COL, 32'h0000_0880);
        write_reg(REG_CTR_ROW, 32'hFFF0_0800);
        random_phase(200, 24);

        idle_pct = 65;
        write_reg(REG_RPC, 32'hFFFF_FFFF);
        write_reg(REG_CTR_COL, 32'd524288);
        write_reg(REG_CTR_ROW, 32'd0);
        random_phase(100, 2047);
        write_reg(REG_CTR_COL, 32'h000F_FFFF);
        write_reg(REG_CTR_ROW, 32'h000F_FFFF);
        random_phase(100, 2047);

        // One row a column steps one bin further from the centre with every pixel.
        idle_pct = 0;
        write_reg(REG_RPC, 32'd0);
        write_reg(REG_CTR_COL, 32'd0);
        write_reg(REG_CTR_ROW, 32'd0);
        issue(CMD_CLEAR, '0, '0, 0, '0);
        for (int i = 0; i < 120; i++) begin
            issue(CMD_ACCUM, PIX_W'($urandom), '0, 0, '0);
            if (i % 40 == 0 || i > 115)
                issue(CMD_READ, '0, SEL_W'($urandom_range(3)), 0, '0);
        end
        issue(CMD_READ, '0, 11'd2047, 0, '0);

        write_reg(REG_RPC, 32'd2048);
        write_reg(REG_CTR_COL, 32'd300);
        write_reg(REG_CTR_ROW, 32'd700);
        random_phase(200, 12);

        settle();
        repeat (50) @(negedge clk);
        if (errors == 0) begin
            $display("All tests passed");
        end
        else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/rpb_pkg.sv
design/rpb_ram.sv
design/radial_profile_binning.sv
test/radial_profile_binning_test.sv
